// ----- design/dhcp_pkg.sv -----
package dhcp_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 1024;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_BYTE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_DISCOVER = 2'd1,
    ACT_REQUEST  = 2'd2
  } act_t;

  localparam logic [2:0] ST_INIT       = 3'd0;
  localparam logic [2:0] ST_SELECTING  = 3'd1;
  localparam logic [2:0] ST_REQUESTING = 3'd2;
  localparam logic [2:0] ST_BOUND      = 3'd3;
  localparam logic [2:0] ST_RENEWING   = 3'd4;
  localparam logic [2:0] ST_REBINDING  = 3'd5;

  localparam logic [2:0] PH_TAG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_VAL0 = 3'd2;
  localparam logic [2:0] PH_VALX = 3'd6;
  localparam logic [2:0] PH_DONE = 3'd7;

  localparam logic [7:0] TAG_PAD    = 8'd0;
  localparam logic [7:0] TAG_TYPE   = 8'd53;
  localparam logic [7:0] TAG_LEASE  = 8'd51;
  localparam logic [7:0] TAG_SERVER = 8'd54;
  localparam logic [7:0] TAG_END    = 8'd255;
  localparam logic [7:0] MSG_OFFER  = 8'd2;
  localparam logic [7:0] MSG_ACK    = 8'd5;
  localparam logic [7:0] OP_REPLY   = 8'd2;

  function automatic logic [7:0] cookie_byte(input logic [1:0] i);
    unique case (i)
      2'd0: cookie_byte = 8'd99;
      2'd1: cookie_byte = 8'd130;
      2'd2: cookie_byte = 8'd83;
      default: cookie_byte = 8'd99;
    endcase
  endfunction

  typedef struct packed {
    logic [7:0]  op;
    logic [31:0] yiaddr;
    logic [7:0]  msg_type;
    logic [31:0] lease;
    logic [31:0] server;
    logic        type_seen;
    logic        lease_seen;
    logic        server_seen;
    logic        long_enough;
  } fields_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic       rx_last;
  } item_t;

endpackage

// ----- design/dhcp_parser.sv -----
module dhcp_parser import dhcp_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    byte_en,
  input  logic    last,
  input  logic [7:0] rx_byte,
  output fields_t fields_next
);

  localparam int OW = $clog2(MAX_PACKET_BYTES + 1);

  logic [OW-1:0] byte_offset, offset_next;
  logic [2:0]    phase, phase_next;
  logic [15:0]   tag_len, tag_len_next;
  logic [31:0]   shift, shift_next;
  fields_t       fields;

  always_comb begin
    logic [7:0] tag, rem;
    logic [2:0] idx;
    fields_next  = fields;
    offset_next  = byte_offset;
    phase_next   = phase;
    tag_len_next = tag_len;
    shift_next   = shift;
    tag = tag_len[15:8];
    rem = tag_len[7:0];
    idx = phase - PH_VAL0;
    if (byte_en && (32'(byte_offset) < 32'(MAX_PACKET_BYTES))) begin
      offset_next = byte_offset + 1'b1;
      if (32'(byte_offset) >= 32'd240) fields_next.long_enough = 1'b1;
      if (byte_offset == '0) begin
        fields_next.op = rx_byte;
      end else if (32'(byte_offset) >= 16 && 32'(byte_offset) <= 19) begin
        fields_next.yiaddr = {fields.yiaddr[23:0], rx_byte};
      end else if (32'(byte_offset) >= 236 && 32'(byte_offset) <= 239) begin
        if (rx_byte != cookie_byte(byte_offset[1:0])) phase_next = PH_DONE;
      end else if (32'(byte_offset) >= 240 && phase != PH_DONE) begin
        if (phase == PH_TAG) begin
          if (rx_byte == TAG_END) phase_next = PH_DONE;
          else if (rx_byte != TAG_PAD) begin
            tag_len_next = {rx_byte, 8'd0};
            phase_next   = PH_LEN;
          end
        end else if (phase == PH_LEN) begin
          tag_len_next = {tag, rx_byte};
          shift_next   = '0;
          phase_next   = (rx_byte == 8'd0) ? PH_TAG : PH_VAL0;
        end else begin
          if (idx < 3'd4) shift_next = {shift[23:0], rx_byte};
          if (idx == 3'd0 && tag == TAG_TYPE && !fields.type_seen) begin
            fields_next.msg_type  = rx_byte;
            fields_next.type_seen = 1'b1;
          end
          if (idx == 3'd3) begin
            if (tag == TAG_LEASE && !fields.lease_seen) begin
              fields_next.lease      = shift_next;
              fields_next.lease_seen = 1'b1;
            end else if (tag == TAG_SERVER && !fields.server_seen) begin
              fields_next.server      = shift_next;
              fields_next.server_seen = 1'b1;
            end
          end
          tag_len_next = {tag, rem - 8'd1};
          if (rem == 8'd1) phase_next = PH_TAG;
          else if (phase < PH_VALX) phase_next = phase + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (byte_en && last)) begin
      byte_offset <= '0;
      phase       <= PH_TAG;
      tag_len     <= '0;
      shift       <= '0;
      fields      <= '0;
    end else begin
      byte_offset <= offset_next;
      phase       <= phase_next;
      tag_len     <= tag_len_next;
      shift       <= shift_next;
      fields      <= fields_next;
    end
  end

endmodule

// ----- design/dhcp_control.sv -----
module dhcp_control import dhcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [1:0]  op,
  input  logic        rx_last,
  input  fields_t     fields,
  input  logic        cfg_write,
  input  logic        cfg_data,
  output logic [1:0]  action,
  output logic        apply_ip,
  output logic [31:0] your_ip,
  output logic [31:0] server_ident,
  output logic [15:0] elapsed_seconds,
  output logic [2:0]  client_state
);

  logic        enable;
  logic [2:0]  state, state_next;
  logic [31:0] t1, t1_next, t2, t2_next, lease, lease_next;
  logic        t1_run, t1_run_next, t2_run, t2_run_next;
  logic [15:0] secs, secs_next;
  logic [31:0] yi, yi_next, srv, srv_next;
  logic        srv_ok, srv_ok_next;
  logic [1:0]  act;
  logic        app;
  logic [34:0] lease7;

  always_comb begin
    logic reply;
    logic [7:0] mtype;
    state_next = state; t1_next = t1; t2_next = t2; lease_next = lease;
    t1_run_next = t1_run; t2_run_next = t2_run; secs_next = secs;
    yi_next = yi; srv_next = srv; srv_ok_next = srv_ok;
    act = ACT_NONE; app = 1'b0;
    reply = fields.op == OP_REPLY;
    mtype = fields.type_seen ? fields.msg_type : 8'd0;
    lease7 = {3'd0, fields.lease} * 35'd7;
    unique case (op)
      OP_START: begin
        if (enable && state == ST_INIT) begin
          act = ACT_DISCOVER; t1_next = 32'd3; t1_run_next = 1'b1;
          state_next = ST_SELECTING;
        end
      end
      OP_TICK: begin
        if (enable && secs != 16'hffff) secs_next = secs + 16'd1;
        if (t1_run) begin
          if (t1 <= 32'd1) begin
            t1_run_next = 1'b0; t1_next = '0;
            if (enable) begin
              unique case (state)
                ST_SELECTING: begin
                  act = ACT_DISCOVER; t1_next = 32'd5; t1_run_next = 1'b1;
                end
                ST_REQUESTING, ST_RENEWING, ST_REBINDING: begin
                  if (srv_ok) act = ACT_REQUEST;
                  t1_next = 32'd5; t1_run_next = 1'b1;
                end
                ST_BOUND: begin
                  t1_next = 32'd1; t1_run_next = 1'b1; state_next = ST_RENEWING;
                end
                default: ;
              endcase
            end
          end else t1_next = t1 - 32'd1;
        end
        if (t2_run) begin
          if (t2 <= 32'd1) begin
            t2_run_next = 1'b0; t2_next = '0;
            if (enable) begin
              unique case (state_next)
                ST_SELECTING: begin
                  act = ACT_DISCOVER; t1_next = 32'd5; t1_run_next = 1'b1;
                end
                ST_REQUESTING: begin
                  if (srv_ok) act = ACT_REQUEST;
                  t1_next = 32'd5; t1_run_next = 1'b1;
                end
                ST_BOUND: begin
                  t1_next = 32'd1; t1_run_next = 1'b1; state_next = ST_RENEWING;
                end
                ST_RENEWING: begin
                  t1_next = 32'd1; t1_run_next = 1'b1;
                  t2_next = {3'd0, lease[31:3]}; t2_run_next = 1'b1;
                  state_next = ST_REBINDING;
                end
                ST_REBINDING: begin
                  t1_next = '0; t1_run_next = 1'b0;
                  t2_next = '0; t2_run_next = 1'b0;
                  state_next = ST_INIT;
                end
                default: ;
              endcase
            end
          end else t2_next = t2 - 32'd1;
        end
      end
      OP_BYTE: begin
        if (rx_last && enable && fields.long_enough) begin
          unique case (state)
            ST_SELECTING: begin
              t1_next = 32'd5; t1_run_next = 1'b1;
              if (reply && mtype == MSG_OFFER) begin
                yi_next = fields.yiaddr;
                srv_next = fields.server_seen ? fields.server : '0;
                srv_ok_next = fields.server_seen;
                app = 1'b1;
                if (fields.server_seen) act = ACT_REQUEST;
                state_next = ST_REQUESTING;
              end
            end
            ST_REQUESTING, ST_RENEWING, ST_REBINDING: begin
              if (!reply || mtype != MSG_ACK) begin
                t1_next = 32'd5; t1_run_next = 1'b1;
              end else begin
                if (fields.lease_seen) begin
                  lease_next = fields.lease;
                  t1_next = {1'b0, fields.lease[31:1]}; t1_run_next = 1'b1;
                  t2_next = lease7[34:3]; t2_run_next = 1'b1;
                end
                state_next = ST_BOUND;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0; state <= ST_INIT; t1 <= '0; t2 <= '0; lease <= '0;
      t1_run <= 1'b0; t2_run <= 1'b0; secs <= '0; yi <= '0; srv <= '0;
      srv_ok <= 1'b0; action <= ACT_NONE; apply_ip <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_data) begin
        if (!enable) begin
          enable <= 1'b1; state <= ST_INIT; t1 <= '0; t2 <= '0;
          t1_run <= 1'b0; t2_run <= 1'b0; secs <= '0;
        end
      end else enable <= 1'b0;
    end else if (step) begin
      state <= state_next; t1 <= t1_next; t2 <= t2_next; lease <= lease_next;
      t1_run <= t1_run_next; t2_run <= t2_run_next; secs <= secs_next;
      yi <= yi_next; srv <= srv_next; srv_ok <= srv_ok_next;
      action <= act; apply_ip <= app;
    end
  end

  assign your_ip         = yi;
  assign server_ident    = srv_ok ? srv : '0;
  assign elapsed_seconds = secs;
  assign client_state    = state;

endmodule

// ----- design/dhcp_client_fsm.sv -----
// channel  dir  width  contents
// s_axis   in   16     tdata = operation, rx_byte; tlast = rx_last
// m_axis   out  88     tdata = action .. bound
// cfg      in   1      client_enable
// one item per cycle while m_axis is not stalled; the result register loads on the accepting edge
// the result register and state update together; stall holds both
// cfg is taken only while no item is offered or waiting
// rst is synchronous and clears all control state
module dhcp_client_fsm import dhcp_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // operation[1:0], rx_byte[9:2], zero
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,
  // action[1:0], apply_ip[2], your_ip[34:3], server_ident[66:35],
  // elapsed_seconds[82:67], client_state[85:83], bound[86], zero
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);

  item_t      item;
  logic       step, byte_en;
  fields_t    fields_next;
  logic [1:0] action;
  logic       apply_ip;
  logic [31:0] your_ip, server_ident;
  logic [15:0] elapsed_seconds;
  logic [2:0] client_state;
  logic       bound;
  logic       cfg_write;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = !s_axis_tvalid && !m_axis_tvalid;
  assign cfg_write     = cfg_valid && cfg_ready;
  assign item.op       = s_axis_tdata[1:0];
  assign item.rx_byte  = s_axis_tdata[9:2];
  assign item.rx_last  = s_axis_tlast;
  assign byte_en       = step && item.op == OP_BYTE;

  dhcp_parser #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_parser (
    .clk, .rst, .byte_en, .last(item.rx_last), .rx_byte(item.rx_byte),
    .fields_next
  );

  dhcp_control u_ctrl (
    .clk, .rst, .step, .op(item.op), .rx_last(item.rx_last),
    .fields(fields_next), .cfg_write, .cfg_data,
    .action, .apply_ip, .your_ip, .server_ident, .elapsed_seconds, .client_state
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (step) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign bound = client_state == ST_BOUND || client_state == ST_RENEWING ||
                 client_state == ST_REBINDING;
  assign m_axis_tdata = {1'b0, bound, client_state, elapsed_seconds, server_ident,
                         your_ip, apply_ip, action};

endmodule
